FILE: design/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence tracker:
// sequencer states, the result record and the data widths.
// ----------------------------------------------------------------------------
package lis_pkg;

    // Default depth of the tail table
    localparam int unsigned MAX_LEN_DEF = 1024;

    // Width of one stream value
    localparam int unsigned DATA_W = 32;

    // Width of the reported length field
    localparam int unsigned LEN_OUT_W = 11;

    // Flip the sign bit so that an unsigned compare gives signed order
    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic REG_ALLOW_EQUAL = 1'b0;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP_CMP,
        S_SRCH_CMP,
        S_DONE
    } t_seq_state;

    // One finished result, handed from the sequencer to the output stage
    typedef struct packed {
        logic [LEN_OUT_W-1:0] len;
        logic                 last;
        logic                 ovf;
    } t_result;

endpackage

FILE: design/lis_tail_ram.sv
// ----------------------------------------------------------------------------
// lis_tail_ram
// Tail table memory: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module lis_tail_ram
    import lis_pkg::*;
#(
    parameter int unsigned DEPTH  = MAX_LEN_DEF,
    parameter int unsigned ADDR_W = $clog2(MAX_LEN_DEF)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/lis_seq.sv
// ----------------------------------------------------------------------------
// lis_seq
// Sequencer around one shared key comparator: checks a new key against the
// top tail, then binary-searches the tail memory for the slot to replace,
// one probe per cycle, and updates the running length and overflow flag.
// ----------------------------------------------------------------------------
module lis_seq
    import lis_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF,
    parameter int unsigned ADDR_W  = $clog2(MAX_LEN_DEF),
    parameter int unsigned LEN_W   = $clog2(MAX_LEN_DEF + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    input  logic                     i_allow_equal,
    // tail memory
    output logic                     o_rd_en,
    output logic [ADDR_W-1:0]        o_rd_addr,
    input  logic [DATA_W-1:0]        i_rd_data,
    output logic                     o_wr_en,
    output logic [ADDR_W-1:0]        o_wr_addr,
    output logic [DATA_W-1:0]        o_wr_data,
    // result side
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res
);

    t_seq_state        r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_key, n_key;
    logic              r_last, n_last;
    logic [ADDR_W-1:0] r_lo, n_lo;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic [ADDR_W-1:0] r_mid, n_mid;

    logic [DATA_W-1:0] key_in;
    logic              go_left;
    logic [ADDR_W-1:0] top_idx;
    logic [ADDR_W-1:0] s_lo;
    logic [ADDR_W-1:0] s_hi;

    assign key_in  = i_value ^ SIGN_FLIP;
    assign top_idx = ADDR_W'(r_len - LEN_W'(1));

    // Shared comparator: stored tail lies to the right of the key
    assign go_left = i_allow_equal ? (i_rd_data > r_key) : (i_rd_data >= r_key);

    // Narrow the search window from the probe just read
    always_comb begin
        if (go_left) begin
            s_lo = r_lo;
            s_hi = r_mid;
        end else begin
            s_lo = r_mid + ADDR_W'(1);
            s_hi = r_hi;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_last <= n_last;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
    end

    // Next state and memory commands
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_key     = r_key;
        n_last    = r_last;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        o_in_ready  = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_mid;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_lo;
        o_wr_data   = r_key;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // take no request while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_key  = key_in;
                    n_last = i_last;
                    if (r_len == '0) begin
                        // first item of a run: open the table
                        o_wr_en   = 1'b1;
                        o_wr_addr = '0;
                        o_wr_data = key_in;
                        n_len     = LEN_W'(1);
                        n_state   = S_DONE;
                    end else begin
                        // fetch the top tail
                        o_rd_en   = 1'b1;
                        o_rd_addr = top_idx;
                        n_state   = S_TOP_CMP;
                    end
                end
            end

            S_TOP_CMP: begin
                if (!go_left) begin
                    // extend, or saturate when the table is full
                    if (r_len < LEN_W'(MAX_LEN)) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = ADDR_W'(r_len);
                        n_len     = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (top_idx == '0) begin
                    // single entry: replace it
                    o_wr_en   = 1'b1;
                    o_wr_addr = '0;
                    n_state   = S_DONE;
                end else begin
                    // start the search over [0, top)
                    n_lo      = '0;
                    n_hi      = top_idx;
                    n_mid     = top_idx >> 1;
                    o_rd_en   = 1'b1;
                    o_rd_addr = top_idx >> 1;
                    n_state   = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_lo == s_hi) begin
                    // slot found: replace its tail
                    o_wr_en   = 1'b1;
                    o_wr_addr = s_lo;
                    n_state   = S_DONE;
                end else begin
                    // probe the middle of the remaining window
                    n_mid     = s_lo + ((s_hi - s_lo) >> 1);
                    o_rd_en   = 1'b1;
                    o_rd_addr = s_lo + ((s_hi - s_lo) >> 1);
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_last) begin
                        n_len = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.len  = LEN_OUT_W'(r_len);
    assign o_res.last = r_last;
    assign o_res.ovf  = r_ovf;

endmodule

FILE: design/lis_length_tracker.sv
// ----------------------------------------------------------------------------
// lis_length_tracker
// Running length of the longest increasing subsequence of a value stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata carries one signed 32-bit value, tlast ends the run.
//   Master stream: one result per request; tdata carries the running length
//   (bits 10:0), tlast copies the request's tlast, tuser is the sticky
//   overflow flag. After a result with tlast the length restarts at zero.
//   APB register 0 (allow_equal, bit 0): 0 strictly increasing runs,
//   1 non-decreasing runs. Write it only while no request is in progress.
// Sequence:
//   A request that opens the table writes the first tail; otherwise the top
//   tail is read and the table is extended, its one entry replaced, or the
//   tail memory binary-searched (one probe a cycle through the single memory
//   read port) for the slot to replace. One request is worked on at a time.
// Reset and stalls:
//   Reset clears the length, the overflow flag and allow_equal; the tail
//   memory needs no clearing. A finished result waits in the output
//   register, the next request is taken meanwhile, and the sequencer holds
//   only when it has a second result and the receiver still stalls.
// ----------------------------------------------------------------------------
module lis_length_tracker
    import lis_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                     s_axis_tlast,
    // master stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,   // [10:0] length, [15:11] zero
    output logic                     m_axis_tlast,
    output logic                     m_axis_tuser,   // [0] overflow
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned ADDR_W = $clog2(MAX_LEN);
    localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);

    logic              r_allow_equal;
    logic              r_out_valid;
    t_result           r_out;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ALLOW_EQUAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_equal <= 1'b0;
        end else if (cfg_wr) begin
            r_allow_equal <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_ALLOW_EQUAL) ? {31'b0, r_allow_equal} : '0;

    // Tail memory
    lis_tail_ram #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Search sequencer
    lis_seq #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W),
        .LEN_W   (LEN_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_value       (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_allow_equal (r_allow_equal),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - LEN_OUT_W){1'b0}}, r_out.len};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.ovf;

endmodule

FILE: verif/lis_length_checker.sv
// ----------------------------------------------------------------------------
// lis_length_checker
// Watches the value stream, the length stream and the register port of the
// longest increasing subsequence tracker. Keeps its own patience table,
// predicts one length report per accepted request and compares each report
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lis_length_checker
    import lis_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // value stream
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                     s_axis_tlast,
    // length stream
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [15:0]              m_axis_tdata,   // [10:0] length, [15:11] zero
    input  logic                     m_axis_tlast,
    input  logic                     m_axis_tuser,   // [0] overflow
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    // status towards the testbench top
    output int                       o_pending,
    output int                       o_fail_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    // Patience table: smallest tail seen for each subsequence length
    logic signed [DATA_W-1:0] tail_val [MAX_LEN];
    int unsigned              run_len;
    logic                     ovf_flag;
    logic                     eq_ok;

    // Length reports still owed by the block, oldest first
    t_result                  length_reports [$];

    int                       req_taken;
    int                       rep_taken;
    int                       fail_cnt;

    assign o_pending  = req_taken - rep_taken;
    assign o_fail_cnt = fail_cnt;

    // Fold one value into the table and return the report it causes
    function automatic t_result patience_step(input logic signed [DATA_W-1:0] v,
                                              input logic lst);
        t_result     rep;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic        grow;
        logic        go_left;
        if (run_len == 0) begin
            tail_val[0] = v;
            run_len     = 1;
        end else begin
            grow = eq_ok ? (v >= tail_val[run_len-1]) : (v > tail_val[run_len-1]);
            if (grow) begin
                if (run_len < MAX_LEN) begin
                    tail_val[run_len] = v;
                    run_len++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end else begin
                // binary search for the first tail that the value may replace
                lo = 0;
                hi = run_len;
                while (lo < hi) begin
                    mid     = lo + (hi - lo) / 2;
                    go_left = eq_ok ? (tail_val[mid] > v) : (tail_val[mid] >= v);
                    if (go_left) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
                if (lo < run_len) tail_val[lo] = v;
            end
        end
        rep.len  = LEN_OUT_W'(run_len);
        rep.last = lst;
        rep.ovf  = ovf_flag;
        if (lst) run_len = 0;
        return rep;
    endfunction

    // Compare reports, predict reports from requests, follow register writes
    always @(posedge i_clk) begin : watch
        t_result want;
        int      bad;
        int      got_rep;
        int      got_req;
        bad     = 0;
        got_rep = 0;
        got_req = 0;
        if (!i_rst_n) begin
            run_len  = 0;
            ovf_flag = 1'b0;
            eq_ok    = 1'b0;
            length_reports.delete();
            req_taken <= 0;
            rep_taken <= 0;
            fail_cnt  <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_rep = 1;
                if (length_reports.size() == 0) begin
                    $error("length report with none outstanding: length %0d",
                           m_axis_tdata[LEN_OUT_W-1:0]);
                    bad++;
                end else begin
                    want = length_reports.pop_front();
                    if (m_axis_tdata[LEN_OUT_W-1:0] !== want.len) begin
                        $error("length: expected %0d, got %0d",
                               want.len, m_axis_tdata[LEN_OUT_W-1:0]);
                        bad++;
                    end
                    if (m_axis_tdata[15:LEN_OUT_W] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[15:LEN_OUT_W]);
                        bad++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_result: expected %0b, got %0b",
                               want.last, m_axis_tlast);
                        bad++;
                    end
                    if (m_axis_tuser !== want.ovf) begin
                        $error("overflow: expected %0b, got %0b",
                               want.ovf, m_axis_tuser);
                        bad++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got_req = 1;
                length_reports = {length_reports, patience_step(s_axis_tdata, s_axis_tlast)};
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_ALLOW_EQUAL) begin
                eq_ok = pwdata[0];
            end
            req_taken <= req_taken + got_req;
            rep_taken <= rep_taken + got_rep;
            fail_cnt  <= fail_cnt + bad;
        end
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the longest increasing subsequence tracker.
// Drives directed runs at the value extremes and with repeated values in both
// compare modes, then random runs of wide, narrow, rising and falling values,
// and one long rising run that fills the tail table. Both streams idle at
// random; a separate checker predicts and compares every length report.
// ----------------------------------------------------------------------------
module tb_top
    import lis_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TB_MAX_LEN = MAX_LEN_DEF;
    localparam int          SETTLE     = 16;
    localparam int          LIMIT      = 1000;
    localparam int          OVF_RUN    = 1100;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_RAMP,
        MIX_FALL
    } t_run_kind;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata  = '0;    // [31:0] value
    logic                     s_axis_tlast  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [15:0]              m_axis_tdata;          // [10:0] length, [15:11] zero
    logic                     m_axis_tlast;
    logic                     m_axis_tuser;          // [0] overflow
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [2:0]               paddr         = '0;
    logic [31:0]              pwdata        = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int                       pending;
    int                       fail_cnt;

    logic signed [DATA_W-1:0] run_vals [$];
    logic                     no_idle = 1'b0;
    int                       n_items = 0;
    int                       n_runs  = 0;
    int                       n_writes = 0;
    int                       idle_cycles = 0;
    logic                     sat_seen = 1'b0;

    lis_length_tracker #(
        .MAX_LEN (TB_MAX_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lis_length_checker #(
        .MAX_LEN (TB_MAX_LEN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_pending     (pending),
        .o_fail_cnt    (fail_cnt)
    );

    // Generate the clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 11) == 0) return int'($urandom_range(20, 60));
        return int'($urandom_range(0, 3));
    endfunction

    // Stall the receiver at random, with long stretches of steady ready
    initial begin : rx_stall
        int run;
        int gap;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 15) == 0) ? int'($urandom_range(40, 150))
                                               : int'($urandom_range(1, 6));
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (psel && penable && pready)) begin
            idle_cycles <= 0;
            if (m_axis_tvalid && m_axis_tready && m_axis_tuser) sat_seen <= 1'b1;
        end else if (idle_cycles == LIMIT) begin
            $display("lis_length_tracker: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold the sender until every outstanding report has come back
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Drain, let the block settle, then write the compare mode
    task automatic set_mode(input logic eq);
        logic [31:0] noise;
        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ALLOW_EQUAL, 2'b00};
        pwdata  <= {noise[31:1], eq};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    // Send the queued run, tlast on its final value
    task automatic send_run();
        int gap;
        for (int k = 0; k < run_vals.size(); k++) begin
            gap = no_idle ? 0 : pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= run_vals[k];
            s_axis_tlast  <= (k == run_vals.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            n_items++;
        end
        n_runs++;
    endtask

    // Random runs in one compare mode until the item budget is spent
    task automatic random_phase(input logic eq, input int target);
        int                       start;
        int                       len;
        t_run_kind                kind;
        logic signed [DATA_W-1:0] v;
        set_mode(eq);
        start = n_items;
        while (n_items - start < target) begin
            len  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(41, 150))
                                               : int'($urandom_range(1, 40));
            kind = t_run_kind'($urandom_range(0, 3));
            v    = $urandom();
            run_vals.delete();
            for (int k = 0; k < len; k++) begin
                case (kind)
                    MIX_WIDE: begin
                        v = $urandom();
                    end
                    MIX_NARROW: begin
                        v = 32'($urandom_range(0, 12)) - 32'd6;
                    end
                    MIX_RAMP: begin
                        if ($urandom_range(0, 7) == 0) v = v - 32'($urandom_range(0, 50));
                        else v = v + 32'($urandom_range(0, 3));
                    end
                    default: begin
                        v = v - 32'($urandom_range(0, 4));
                    end
                endcase
                run_vals = {run_vals, v};
            end
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 24) == 0) wait_results_done();
            send_run();
        end
    endtask

    initial begin : stimulus
        logic signed [DATA_W-1:0] v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Strict mode: extremes, equal values and replacements at both ends
        set_mode(1'b0);
        run_vals = '{32'sh8000_0000};
        send_run();
        run_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'sd0,
                     32'sh8000_0000, -32'sd1, 32'sd1, 32'sd2};
        send_run();
        run_vals = '{32'sh7fff_ffff};
        send_run();

        // Non-decreasing mode: equal values extend the table
        set_mode(1'b1);
        run_vals = '{32'sd3, 32'sd3, 32'sd3, -32'sd5, 32'sd3,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
        send_run();
        run_vals = '{-32'sd1, -32'sd2};
        send_run();

        // Random runs across both modes
        random_phase(1'b0, 300);
        random_phase(1'b1, 300);
        random_phase(1'b0, 300);

        // Fill the table with a long rising run, then push past its end
        set_mode(1'b1);
        run_vals.delete();
        v = 32'sh8000_0000 + 32'(2000 + $urandom_range(0, 100));
        for (int k = 0; k < OVF_RUN; k++) begin
            if ($urandom_range(0, 31) == 0) begin
                run_vals = {run_vals, v - 32'($urandom_range(1, 1000))};
            end else begin
                v = v + 32'($urandom_range(0, 2));
                run_vals = {run_vals, v};
            end
        end
        no_idle = 1'b0;
        send_run();

        // Short runs after saturation: the overflow flag must stay up
        random_phase(1'b1, 50);
        random_phase(1'b0, 50);

        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d requests in %0d runs with %0d mode writes, both compare modes",
                 n_items, n_runs, n_writes);
        $display("tail table saturation reported: %0b", sat_seen);
        if (fail_cnt == 0 && pending == 0) begin
            $display("lis_length_tracker: match");
        end else begin
            $display("lis_length_tracker: mismatch");
        end
        $finish;
    end

endmodule
